/* rtl/lzd_pkg.sv */
// lzd_pkg: command format between the parser front and the copy back end
// of the lz77 window decompressor. no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package lzd_pkg;

  localparam int unsigned SIZE_W      = 24;
  localparam int unsigned DISP_W      = 12;
  localparam int unsigned LEN_W       = 5;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam logic [LEN_W-1:0] LEN_BIAS = LEN_W'(3);

  typedef enum logic [1:0] {
    CMD_START,
    CMD_LIT,
    CMD_COPY
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e         kind;
    logic [7:0]        data;
    logic [LEN_W-1:0]  len;
    logic [DISP_W-1:0] disp;
    logic              ends;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } push_t;

endpackage
`default_nettype wire

/* rtl/lzd_if.sv */
// lzd_if: valid/ready channel interfaces for compressed input and
// decompressed output items. no dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface lzd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_first;
  modport source (output valid, in_byte, in_first, input ready);
  modport sink   (input valid, in_byte, in_first, output ready);
endinterface

interface lzd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;
  logic       out_bad_ref;
  modport source (output valid, out_byte, out_last, out_bad_ref, input ready);
  modport sink   (input valid, out_byte, out_last, out_bad_ref, output ready);
endinterface
`default_nettype wire

/* rtl/lz77_window_decompressor_top.sv */
// lz77_window_decompressor_top: lz77 type 0x10 stream decompressor.
// depends on lzd_pkg, lzd_if, lzd_front, lzd_queue and lzd_back.
//
//   channel  dir  payload                          accepted when
//   in_i     in   in_byte[7:0], in_first           valid && ready
//   out_o    out  out_byte[7:0], out_last, bad_ref valid && ready
//
// the front takes one compressed item per cycle while the command queue has room.
// a literal is registered into the output when its command reaches the back end and
// the output register is free; a reference first reads the window, then gives one byte
// per cycle while the output is not stalled, up to 18, set by the single read port of the history memory.
// reset clears control state only; the history memory holds no reset value.
// either side may stall: the queue decouples parsing from output stalls.
`timescale 1ns / 1ps
`default_nettype none
module lz77_window_decompressor_top #(
  parameter int unsigned WINDOW_DEPTH = 4096
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  lzd_in_if.sink     in_i,
  lzd_out_if.source  out_o
);
  import lzd_pkg::*;

  push_t push;
  cmd_t  head;
  logic  q_full;
  logic  q_valid;
  logic  q_pop;

  lzd_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .q_full_i (q_full),
    .push_o   (push)
  );

  lzd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (q_pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .head_o  (head)
  );

  lzd_back #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_head_i  (head),
    .q_pop_o   (q_pop),
    .out_o     (out_o)
  );

endmodule
`default_nettype wire

/* rtl/lzd_front.sv */
// lzd_front: parses header, flag bytes, literals and references into commands.
// depends on lzd_pkg and lzd_if.
`timescale 1ns / 1ps
`default_nettype none
module lzd_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  lzd_in_if.sink             in_i,
  input  wire logic          q_full_i,
  output lzd_pkg::push_t     push_o
);
  import lzd_pkg::*;

  typedef enum logic [2:0] {
    PH_WAIT,
    PH_HEADER,
    PH_FLAG,
    PH_DATA,
    PH_REF2,
    PH_DONE
  } phase_e;

  phase_e              phase_q, phase_d;
  logic [1:0]          hdr_idx_q, hdr_idx_d;
  logic [SIZE_W-1:0]   target_q, target_d;
  logic [SIZE_W-1:0]   prod_q, prod_d;
  logic [7:0]          flags_q, flags_d;
  logic [2:0]          fpos_q, fpos_d;
  logic [7:0]          held_q, held_d;

  logic                accept;
  logic [7:0]          b;
  logic [LEN_W-1:0]    ref_len;
  logic [SIZE_W-1:0]   remaining;
  logic                ref_ends;
  logic [LEN_W-1:0]    ref_n;
  logic [SIZE_W-1:0]   prod_inc;
  logic                lit_ends;

  assign in_i.ready = !q_full_i;
  assign accept     = in_i.valid && !q_full_i;
  assign b          = in_i.in_byte;

  assign ref_len   = LEN_W'(held_q[7:4]) + LEN_BIAS;
  assign remaining = target_q - prod_q;
  assign ref_ends  = (SIZE_W'(ref_len) >= remaining);
  assign ref_n     = ref_ends ? remaining[LEN_W-1:0] : ref_len;
  assign prod_inc  = prod_q + SIZE_W'(1);
  assign lit_ends  = (prod_inc >= target_q);

  always_comb begin
    phase_d   = phase_q;
    hdr_idx_d = hdr_idx_q;
    target_d  = target_q;
    prod_d    = prod_q;
    flags_d   = flags_q;
    fpos_d    = fpos_q;
    held_d    = held_q;
    push_o    = '0;
    push_o.cmd.data = b;
    push_o.cmd.disp = {held_q[3:0], b};
    push_o.cmd.len  = ref_n;
    if (accept) begin
      if (in_i.in_first) begin
        phase_d   = PH_HEADER;
        hdr_idx_d = 2'd1;
        target_d  = '0;
        prod_d    = '0;
        flags_d   = '0;
        fpos_d    = 3'd7;
        held_d    = '0;
        push_o.valid    = 1'b1;
        push_o.cmd.kind = CMD_START;
      end else begin
        unique case (phase_q)
          PH_HEADER: begin
            unique case (hdr_idx_q)
              2'd1:    target_d[7:0]   = b;
              2'd2:    target_d[15:8]  = b;
              2'd3:    target_d[23:16] = b;
              default: target_d = target_q;
            endcase
            if (hdr_idx_q == 2'd3) begin
              hdr_idx_d = 2'd0;
              phase_d   = (target_d == '0) ? PH_DONE : PH_FLAG;
            end else begin
              hdr_idx_d = hdr_idx_q + 2'd1;
            end
          end
          PH_FLAG: begin
            flags_d = b;
            fpos_d  = 3'd7;
            phase_d = PH_DATA;
          end
          PH_DATA: begin
            if (flags_q[fpos_q]) begin
              held_d  = b;
              phase_d = PH_REF2;
            end else begin
              push_o.valid    = 1'b1;
              push_o.cmd.kind = CMD_LIT;
              push_o.cmd.ends = lit_ends;
              prod_d          = prod_inc;
              if (lit_ends) begin
                phase_d = PH_DONE;
              end else if (fpos_q == 3'd0) begin
                phase_d = PH_FLAG;
              end else begin
                fpos_d  = fpos_q - 3'd1;
                phase_d = PH_DATA;
              end
            end
          end
          PH_REF2: begin
            push_o.valid    = 1'b1;
            push_o.cmd.kind = CMD_COPY;
            push_o.cmd.ends = ref_ends;
            prod_d          = prod_q + SIZE_W'(ref_n);
            if (ref_ends) begin
              phase_d = PH_DONE;
            end else if (fpos_q == 3'd0) begin
              phase_d = PH_FLAG;
            end else begin
              fpos_d  = fpos_q - 3'd1;
              phase_d = PH_DATA;
            end
          end
          PH_WAIT, PH_DONE: phase_d = phase_q;
          default:          phase_d = phase_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_WAIT;
      hdr_idx_q <= '0;
      target_q  <= '0;
      prod_q    <= '0;
      flags_q   <= '0;
      fpos_q    <= 3'd7;
      held_q    <= '0;
    end else begin
      phase_q   <= phase_d;
      hdr_idx_q <= hdr_idx_d;
      target_q  <= target_d;
      prod_q    <= prod_d;
      flags_q   <= flags_d;
      fpos_q    <= fpos_d;
      held_q    <= held_d;
    end
  end

endmodule
`default_nettype wire

/* rtl/lzd_queue.sv */
// lzd_queue: short command queue between parser front and copy back end.
// depends on lzd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lzd_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  lzd_pkg::push_t     push_i,
  input  wire logic          pop_i,
  output logic               full_o,
  output logic               valid_o,
  output lzd_pkg::cmd_t      head_o
);
  import lzd_pkg::*;

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  cmd_t            slot_q [QUEUE_DEPTH];
  logic [PW-1:0]   wr_q, rd_q;
  logic [CW-1:0]   cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CW'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = slot_q[rd_q];
  assign do_push = push_i.valid && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= push_i.cmd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + PW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/lzd_back.sv */
// lzd_back: executes start, literal and copy commands against the history window
// and drives the output register. depends on lzd_pkg and lzd_if.
`timescale 1ns / 1ps
`default_nettype none
module lzd_back #(
  parameter int unsigned WINDOW_DEPTH = 4096
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          q_valid_i,
  input  lzd_pkg::cmd_t      q_head_i,
  output logic               q_pop_o,
  lzd_out_if.source          out_o
);
  import lzd_pkg::*;

  localparam int unsigned AW = $clog2(WINDOW_DEPTH);

  typedef enum logic {
    ST_IDLE,
    ST_COPY
  } state_e;

  logic [7:0]        hist_mem [WINDOW_DEPTH];

  state_e            state_q, state_d;
  logic [AW-1:0]     wp_q, wp_d;
  logic [SIZE_W-1:0] prod_q, prod_d;
  logic [7:0]        last_byte_q, last_byte_d;
  logic [LEN_W-1:0]  cnt_q, cnt_d;
  logic [DISP_W-1:0] disp_q, disp_d;
  logic              ends_q, ends_d;
  logic [7:0]        rd_data_q;
  logic              ov_q, ov_d;
  logic [7:0]        obyte_q, obyte_d;
  logic              olast_q, olast_d;
  logic              obad_q, obad_d;

  logic              can_emit;
  logic              emit;
  logic [7:0]        emit_val;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic              copy_bad;

  assign can_emit = !ov_q || out_o.ready;
  assign copy_bad = (SIZE_W'(disp_q) >= prod_q);

  always_comb begin
    state_d     = state_q;
    wp_d        = wp_q;
    prod_d      = prod_q;
    last_byte_d = last_byte_q;
    cnt_d       = cnt_q;
    disp_d      = disp_q;
    ends_d      = ends_q;
    ov_d        = ov_q && !out_o.ready;
    obyte_d     = obyte_q;
    olast_d     = olast_q;
    obad_d      = obad_q;
    q_pop_o     = 1'b0;
    emit        = 1'b0;
    emit_val    = '0;
    rd_en       = 1'b0;
    rd_addr     = wp_q - AW'(q_head_i.disp) - AW'(1);
    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          unique case (q_head_i.kind)
            CMD_START: begin
              q_pop_o = 1'b1;
              prod_d  = '0;
            end
            CMD_LIT: begin
              if (can_emit) begin
                q_pop_o  = 1'b1;
                emit     = 1'b1;
                emit_val = q_head_i.data;
                olast_d  = q_head_i.ends;
                obad_d   = 1'b0;
              end
            end
            CMD_COPY: begin
              q_pop_o = 1'b1;
              rd_en   = 1'b1;
              cnt_d   = q_head_i.len;
              disp_d  = q_head_i.disp;
              ends_d  = q_head_i.ends;
              state_d = ST_COPY;
            end
            default: q_pop_o = 1'b0;
          endcase
        end
      end
      ST_COPY: begin
        rd_addr = wp_q - AW'(disp_q);
        if (can_emit) begin
          emit     = 1'b1;
          emit_val = copy_bad ? 8'd0 : ((disp_q == '0) ? last_byte_q : rd_data_q);
          obad_d   = copy_bad;
          olast_d  = ends_q && (cnt_q == LEN_W'(1));
          if (cnt_q == LEN_W'(1)) begin
            state_d = ST_IDLE;
          end else begin
            cnt_d = cnt_q - LEN_W'(1);
            rd_en = 1'b1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
    if (emit) begin
      ov_d        = 1'b1;
      obyte_d     = emit_val;
      wp_d        = wp_q + AW'(1);
      prod_d      = prod_q + SIZE_W'(1);
      last_byte_d = emit_val;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      hist_mem[wp_q] <= emit_val;
    end
    if (rd_en) begin
      rd_data_q <= hist_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wp_q        <= '0;
      prod_q      <= '0;
      last_byte_q <= '0;
      cnt_q       <= '0;
      disp_q      <= '0;
      ends_q      <= 1'b0;
      ov_q        <= 1'b0;
      obyte_q     <= '0;
      olast_q     <= 1'b0;
      obad_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      wp_q        <= wp_d;
      prod_q      <= prod_d;
      last_byte_q <= last_byte_d;
      cnt_q       <= cnt_d;
      disp_q      <= disp_d;
      ends_q      <= ends_d;
      ov_q        <= ov_d;
      obyte_q     <= obyte_d;
      olast_q     <= olast_d;
      obad_q      <= obad_d;
    end
  end

  assign out_o.valid       = ov_q;
  assign out_o.out_byte    = obyte_q;
  assign out_o.out_last    = olast_q;
  assign out_o.out_bad_ref = obad_q;

endmodule
`default_nettype wire

/* sim/tb.sv */
// tb: self-checking testbench for lz77_window_decompressor_top. compressed
// streams go in through lzd_in_if, and a local decoder checks every output item.
// depends on lzd_pkg, lzd_if and the rtl under rtl/.
`timescale 1ns / 1ps
module tb;

  localparam int unsigned WINDOW     = 4096;
  localparam int unsigned HOLD_AT    = 40;
  localparam int unsigned HOLD_LEN   = 400;
  localparam int unsigned CALM_FROM  = 90;
  localparam int unsigned CALM_TO    = 140;
  localparam int unsigned WATCHDOG   = 3000;
  localparam int unsigned TAIL_WAIT  = 40;
  localparam int unsigned RAND_ITEMS = 60;

  typedef enum logic [2:0] {
    P_IDLE,
    P_HEADER,
    P_FLAGS,
    P_TOKEN,
    P_REF_LO,
    P_DONE
  } parse_e;

  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       drain;
  } comp_item_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       bad;
  } plain_byte_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  lzd_in_if  in_if ();
  lzd_out_if out_if ();

  lz77_window_decompressor_top #(
    .WINDOW_DEPTH(WINDOW)
  ) u_top (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  comp_item_t  comp_q[$];
  plain_byte_t plain_q[$];
  int unsigned in_count = 0;
  int unsigned err_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned stall_left = 0;
  bit          hold_done = 1'b0;

  wire calm = (in_count >= CALM_FROM) && (in_count < CALM_TO);

  // decoder state
  parse_e      phase = P_IDLE;
  logic [1:0]  hdr_idx = '0;
  logic [23:0] target = '0;
  logic [23:0] produced = '0;
  logic [7:0]  flags = '0;
  logic [2:0]  flag_pos = 3'd7;
  logic [7:0]  held = '0;
  logic [7:0]  history [WINDOW];
  logic [11:0] wr_ptr = '0;

  task automatic put_byte(input logic [7:0] v, input logic bad, output bit last);
    history[wr_ptr] = v;
    wr_ptr = wr_ptr + 12'd1;
    produced = produced + 24'd1;
    last = (produced >= target);
    plain_q.push_back('{v, last, bad});
  endtask

  task automatic next_token();
    if (flag_pos == 3'd0) begin
      phase = P_FLAGS;
    end else begin
      flag_pos = flag_pos - 3'd1;
      phase = P_TOKEN;
    end
  endtask

  task automatic decode_item(input logic [7:0] b, input logic first);
    logic [12:0] ref_dist;
    logic [4:0]  len;
    logic [7:0]  v;
    logic        bad;
    bit          done;
    if (first) begin
      phase = P_HEADER;
      hdr_idx = 2'd1;
      target = '0;
      produced = '0;
      flags = '0;
      flag_pos = 3'd7;
      held = '0;
    end else begin
      case (phase)
        P_HEADER: begin
          target[8*(hdr_idx-1) +: 8] = b;
          if (hdr_idx == 2'd3) begin
            hdr_idx = 2'd0;
            phase = (target == '0) ? P_DONE : P_FLAGS;
          end else begin
            hdr_idx = hdr_idx + 2'd1;
          end
        end
        P_FLAGS: begin
          flags = b;
          flag_pos = 3'd7;
          phase = P_TOKEN;
        end
        P_TOKEN: begin
          if (flags[flag_pos]) begin
            held = b;
            phase = P_REF_LO;
          end else begin
            put_byte(b, 1'b0, done);
            if (done) phase = P_DONE;
            else next_token();
          end
        end
        P_REF_LO: begin
          len = {1'b0, held[7:4]} + 5'd3;
          ref_dist = {1'b0, held[3:0], b} + 13'd1;
          done = 1'b0;
          for (int j = 0; j < len && !done; j++) begin
            bad = ({11'd0, ref_dist} > produced);
            v = bad ? 8'h00 : history[wr_ptr - ref_dist[11:0]];
            put_byte(v, bad, done);
          end
          if (done) phase = P_DONE;
          else next_token();
        end
        default: begin
        end
      endcase
    end
  endtask

  task automatic push_item(input logic [7:0] d, input logic f);
    comp_q.push_back('{d, f, 1'b0});
  endtask

  task automatic add_stream(input int unsigned size, input int unsigned ref_pct,
                            input int unsigned bad_pct, input bit max_len,
                            input int unsigned keep, input bit drain);
    logic [7:0]  bytes_q[$];
    logic [7:0]  group_q[$];
    logic [7:0]  fbits;
    logic [11:0] disp;
    logic [3:0]  code;
    int unsigned made;
    int unsigned ref_dist;
    int unsigned reach;
    made = 0;
    bytes_q.push_back(8'($urandom_range(255, 0)));
    bytes_q.push_back(size[7:0]);
    bytes_q.push_back(size[15:8]);
    bytes_q.push_back(size[23:16]);
    while (made < size && (keep == 0 || bytes_q.size() < keep)) begin
      fbits = 8'($urandom_range(255, 0));
      group_q.delete();
      for (int k = 7; k >= 0; k--) begin
        if (made < size) begin
          if ($urandom_range(99, 0) < ref_pct && (made > 0 || bad_pct > 0)) begin
            fbits[k] = 1'b1;
            code = max_len ? 4'hF : 4'($urandom_range(15, 0));
            reach = (made < WINDOW) ? made : WINDOW;
            if (made < WINDOW && (made == 0 || $urandom_range(99, 0) < bad_pct))
              ref_dist = $urandom_range(WINDOW, made + 1);
            else if (max_len && made >= WINDOW)
              ref_dist = WINDOW;
            else if ($urandom_range(1, 0) == 1)
              ref_dist = $urandom_range((reach < 16) ? reach : 16, 1);
            else
              ref_dist = $urandom_range(reach, 1);
            disp = 12'(ref_dist - 1);
            group_q.push_back({code, disp[11:8]});
            group_q.push_back(disp[7:0]);
            made += code + 3;
          end else begin
            fbits[k] = 1'b0;
            group_q.push_back(8'($urandom_range(255, 0)));
            made++;
          end
        end
      end
      bytes_q.push_back(fbits);
      foreach (group_q[i]) bytes_q.push_back(group_q[i]);
    end
    while (keep != 0 && bytes_q.size() > keep) void'(bytes_q.pop_back());
    foreach (bytes_q[i]) comp_q.push_back('{bytes_q[i], i == 0, drain && i == 0});
  endtask

  // driver
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      in_if.in_byte <= 8'h00;
      in_if.in_first <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        decode_item(in_if.in_byte, in_if.in_first);
        in_count <= in_count + 1;
      end
      if (!in_if.valid || in_if.ready) begin
        if (comp_q.size() != 0 && (calm || $urandom_range(99, 0) >= 35) &&
            !(comp_q[0].drain && plain_q.size() != 0)) begin
          in_if.valid <= 1'b1;
          in_if.in_byte <= comp_q[0].data;
          in_if.in_first <= comp_q[0].first;
          void'(comp_q.pop_front());
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk or negedge rst_n) begin
    plain_byte_t want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (plain_q.size() == 0) begin
          $display("%0t: unexpected item: byte %02h last %0b bad_ref %0b", $time,
                   out_if.out_byte, out_if.out_last, out_if.out_bad_ref);
          err_count++;
        end else begin
          want = plain_q.pop_front();
          if (out_if.out_byte !== want.data) begin
            $display("%0t: out_byte expected %02h got %02h", $time, want.data,
                     out_if.out_byte);
            err_count++;
          end
          if (out_if.out_last !== want.last) begin
            $display("%0t: out_last expected %0b got %0b", $time, want.last,
                     out_if.out_last);
            err_count++;
          end
          if (out_if.out_bad_ref !== want.bad) begin
            $display("%0t: out_bad_ref expected %0b got %0b", $time, want.bad,
                     out_if.out_bad_ref);
            err_count++;
          end
        end
      end
      if (!hold_done && in_count >= HOLD_AT) begin
        hold_done <= 1'b1;
        stall_left <= HOLD_LEN;
        out_if.ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= calm || ($urandom_range(99, 0) >= 35);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned base;
    int unsigned pick;
    int unsigned size;
    int unsigned keep;
    int unsigned trail;
    in_if.valid = 1'b0;
    in_if.in_byte = 8'h00;
    in_if.in_first = 1'b0;
    out_if.ready = 1'b0;

    // noise before any stream
    push_item(8'hFF, 1'b0);
    // zero size, then a dropped item
    push_item(8'h10, 1'b1);
    push_item(8'h00, 1'b0);
    push_item(8'h00, 1'b0);
    push_item(8'h00, 1'b0);
    push_item(8'h5A, 1'b0);
    // literals 00 and ff, overlapping copy cut at the size, trailing item
    push_item(8'h10, 1'b1);
    push_item(8'h06, 1'b0);
    push_item(8'h00, 1'b0);
    push_item(8'h00, 1'b0);
    push_item(8'h20, 1'b0);
    push_item(8'h00, 1'b0);
    push_item(8'hFF, 1'b0);
    push_item(8'hF0, 1'b0);
    push_item(8'h00, 1'b0);
    push_item(8'h3C, 1'b0);
    // max size, refs before stream start, partial bad copy, abandon mid-ref
    push_item(8'h10, 1'b1);
    push_item(8'hFF, 1'b0);
    push_item(8'hFF, 1'b0);
    push_item(8'hFF, 1'b0);
    push_item(8'hE0, 1'b0);
    push_item(8'h0F, 1'b0);
    push_item(8'hFF, 1'b0);
    push_item(8'hF0, 1'b0);
    push_item(8'h03, 1'b0);
    push_item(8'h81, 1'b0);
    // abandon mid-header
    push_item(8'h10, 1'b1);
    push_item(8'h02, 1'b0);

    // one stream of longest copies, after a full drain
    add_stream(480, 95, 0, 1'b1, 0, 1'b1);

    base = comp_q.size();
    while (comp_q.size() - base < RAND_ITEMS) begin
      pick = $urandom_range(99, 0);
      keep = 0;
      if (pick < 3) size = 0;
      else if (pick < 8) size = $urandom_range(24'hFFFFFF, 24'h010000);
      else if (pick < 18) size = $urandom_range(3, 1);
      else if (pick < 88) size = $urandom_range(60, 4);
      else size = $urandom_range(200, 61);
      if (size > 24'h00FFFF) keep = $urandom_range(40, 2);
      else if ($urandom_range(99, 0) < 12) keep = $urandom_range(30, 1);
      add_stream(size, $urandom_range(70, 0), ($urandom_range(99, 0) < 30) ? 10 : 0,
                 1'b0, keep, 1'b0);
      if ($urandom_range(99, 0) < 20) begin
        trail = $urandom_range(3, 1);
        repeat (trail) push_item(8'($urandom_range(255, 0)), 1'b0);
      end
    end

    repeat (7) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    while (comp_q.size() != 0 || in_if.valid || plain_q.size() != 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);
    if (err_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

/* lz77_window_decompressor_top.f */
rtl/lzd_pkg.sv
rtl/lzd_if.sv
rtl/lzd_front.sv
rtl/lzd_queue.sv
rtl/lzd_back.sv
rtl/lz77_window_decompressor_top.sv
sim/tb.sv
